FILE: hw/rtl/x86rmd_pkg.sv
package x86rmd_pkg;

    localparam int OFFSET_BITS_DEF = 16;
    localparam int QUEUE_DEPTH     = 4;
    localparam int NUM_BYTES       = 5;

    localparam logic [3:0] FC_NONE    = 4'd0;
    localparam logic [3:0] FC_IMM8    = 4'd1;
    localparam logic [3:0] FC_IMM16   = 4'd2;
    localparam logic [3:0] FC_REGREG  = 4'd3;
    localparam logic [3:0] FC_DISP8   = 4'd4;
    localparam logic [3:0] FC_DISP16  = 4'd5;
    localparam logic [3:0] FC_MEM     = 4'd6;
    localparam logic [3:0] FC_MRM_IMM = 4'd7;
    localparam logic [3:0] FC_REL16   = 4'd8;
    localparam logic [3:0] FC_FAR     = 4'd9;

    localparam logic [7:0] OP_TWO_BYTE = 8'h0f;
    localparam logic [7:0] OP_JMPF     = 8'hea;

    typedef struct packed {
        logic [2:0] len;
        logic [3:0] cls;
        logic       has2;
    } t_form;

    typedef struct packed {
        logic [15:0]                start;
        t_form                      form;
        logic                       fault;
        logic [NUM_BYTES-1:0][7:0]  bytes;
    } t_rec;

    function automatic t_form form_of(input logic [7:0] op, input logic [7:0] b1);
        t_form      f;
        logic [1:0] md;
        f.len  = 3'd0;
        f.cls  = FC_NONE;
        f.has2 = 1'b0;
        md     = b1[7:6];
        if ((op >= 8'h40 && op <= 8'h61) || op == 8'h06 || op == 8'h07 ||
            op == 8'h1e || op == 8'h1f || op == 8'h66 || op == 8'ha4 ||
            op == 8'haa || op == 8'hc3 || op == 8'hf3 || (op >= 8'hfa && op <= 8'hfd)) begin
            f.len = 3'd1;
        end else if ((op >= 8'h74 && op <= 8'h7f) || (op >= 8'hb0 && op <= 8'hb7) ||
                     op == 8'h24 || op == 8'h3c || op == 8'he3 || op == 8'he4 ||
                     op == 8'he6) begin
            f.len = 3'd2;
            f.cls = FC_IMM8;
        end else if (op >= 8'hb8 && op <= 8'hbf) begin
            f.len = 3'd3;
            f.cls = FC_IMM16;
        end else if (op == 8'he8 || op == 8'he9) begin
            f.len = 3'd3;
            f.cls = FC_REL16;
        end else if (op == OP_JMPF) begin
            f.len = 3'd5;
            f.cls = FC_FAR;
        end else begin
            f.has2 = 1'b1;
            case (op)
                OP_TWO_BYTE: begin
                    if (b1 == 8'h84 || b1 == 8'h85) begin
                        f.len = 3'd4;
                        f.cls = FC_REL16;
                    end
                end
                8'h31, 8'h84: begin
                    if (md == 2'b11) begin
                        f.len = 3'd2;
                        f.cls = FC_REGREG;
                    end
                end
                8'h80: begin
                    if ((b1 & 8'hf8) == 8'h00) begin
                        f.len = 3'd3;
                        f.cls = FC_MRM_IMM;
                    end
                end
                8'h83: begin
                    if ((b1 & 8'hf8) == 8'hc0) begin
                        f.len = 3'd3;
                        f.cls = FC_MRM_IMM;
                    end
                end
                8'h88, 8'h89: begin
                    if ((op == 8'h88 && md == 2'b01) ||
                        (op == 8'h89 && (b1 & 8'hc7) == 8'h46)) begin
                        f.len = 3'd3;
                        f.cls = FC_DISP8;
                    end else if (md == 2'b11) begin
                        f.len = 3'd2;
                        f.cls = FC_REGREG;
                    end
                end
                8'h8a: begin
                    if ((b1 & 8'hc7) == 8'h06) begin
                        f.len = 3'd4;
                        f.cls = FC_DISP16;
                    end else if (md == 2'b00) begin
                        f.len = 3'd2;
                        f.cls = FC_MEM;
                    end else if ((b1 & 8'hc7) == 8'h46) begin
                        f.len = 3'd3;
                        f.cls = FC_DISP8;
                    end
                end
                8'h8b, 8'h8d: begin
                    if ((b1 & 8'hc7) == 8'h46) begin
                        f.len = 3'd3;
                        f.cls = FC_DISP8;
                    end
                end
                8'h8c: begin
                    if ((b1 & 8'hf8) == 8'hc8) begin
                        f.len = 3'd2;
                        f.cls = FC_REGREG;
                    end
                end
                8'h8e: begin
                    if (b1 == 8'h5e) begin
                        f.len = 3'd3;
                        f.cls = FC_DISP8;
                    end
                end
                8'hc4, 8'hc5: begin
                    if (md == 2'b01) begin
                        f.len = 3'd3;
                        f.cls = FC_DISP8;
                    end
                end
                default: begin
                end
            endcase
        end
        return f;
    endfunction

endpackage

FILE: hw/rtl/x86rmd_front.sv
module x86rmd_front #(
    parameter int OFFSET_BITS = x86rmd_pkg::OFFSET_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_code_byte,
    output logic              o_push,
    output x86rmd_pkg::t_rec  o_rec
);
    import x86rmd_pkg::*;

    logic [OFFSET_BITS-1:0]     r_offset, n_offset;
    logic [OFFSET_BITS-1:0]     r_start, n_start;
    logic [2:0]                 r_held, n_held;
    t_form                      r_form, n_form;
    logic                       r_halted, n_halted;
    logic [NUM_BYTES-1:0][7:0]  r_bytes, n_bytes;

    logic [OFFSET_BITS-1:0]     start;
    logic [2:0]                 held_new;
    t_form                      f1, f2;

    always_comb begin
        n_offset = r_offset;
        n_start  = r_start;
        n_held   = r_held;
        n_form   = r_form;
        n_halted = r_halted;
        n_bytes  = r_bytes;
        o_push   = 1'b0;

        held_new = r_held + 3'd1;
        start    = (r_held == 3'd0) ? r_offset : r_start;
        f1       = form_of(i_code_byte, 8'h00);
        f2       = form_of(r_bytes[0], i_code_byte);

        if (i_accept && !r_halted) begin
            n_offset         = r_offset + OFFSET_BITS'(1);
            n_start          = start;
            n_bytes[r_held]  = i_code_byte;
        end

        o_rec.start = 16'(start);
        o_rec.form  = r_form;
        o_rec.fault = 1'b0;
        o_rec.bytes = n_bytes;

        if (i_accept && !r_halted) begin
            if (r_held == 3'd0) begin
                if (f1.len == 3'd1) begin
                    o_push          = 1'b1;
                    o_rec.form      = f1;
                    o_rec.form.has2 = 1'b0;
                    n_held          = 3'd0;
                end else begin
                    n_held = 3'd1;
                end
            end else if (r_held == 3'd1) begin
                if (f2.len == 3'd0) begin
                    o_push         = 1'b1;
                    o_rec.form.len = 3'd2;
                    o_rec.form.cls = FC_NONE;
                    o_rec.form.has2 = 1'b0;
                    o_rec.fault    = 1'b1;
                    n_halted       = 1'b1;
                    n_held         = 3'd0;
                end else if (f2.len <= 3'd2) begin
                    o_push     = 1'b1;
                    o_rec.form = f2;
                    n_held     = 3'd0;
                end else begin
                    n_form = f2;
                    n_held = 3'd2;
                end
            end else begin
                if (held_new >= r_form.len || held_new >= 3'(NUM_BYTES)) begin
                    o_push = 1'b1;
                    n_held = 3'd0;
                end else begin
                    n_held = held_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_start  <= '0;
            r_held   <= 3'd0;
            r_form   <= '0;
            r_halted <= 1'b0;
        end else begin
            r_offset <= n_offset;
            r_start  <= n_start;
            r_held   <= n_held;
            r_form   <= n_form;
            r_halted <= n_halted;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
    end

endmodule

FILE: hw/rtl/x86rmd_queue.sv
module x86rmd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  x86rmd_pkg::t_rec  i_rec,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output x86rmd_pkg::t_rec  o_rec
);
    import x86rmd_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    t_rec                r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wptr, n_wptr;
    logic [PTR_BITS-1:0] r_rptr, n_rptr;
    logic [CNT_BITS-1:0] r_count, n_count;
    logic                do_push, do_pop;

    assign o_full  = (r_count == CNT_BITS'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rec   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + PTR_BITS'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + PTR_BITS'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_BITS'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_rec;
        end
    end

endmodule

FILE: hw/rtl/x86rmd_back.sv
module x86rmd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  x86rmd_pkg::t_rec  i_rec,
    output logic              o_pop,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [15:0]       o_start_offset,
    output logic [2:0]        o_instr_length,
    output logic [7:0]        o_opcode_byte,
    output logic [7:0]        o_second_byte,
    output logic [3:0]        o_form_class,
    output logic [15:0]       o_operand_value,
    output logic [15:0]       o_segment_value,
    output logic              o_fault
);
    import x86rmd_pkg::*;

    logic        r_valid;
    logic [15:0] r_start;
    logic [2:0]  r_len;
    logic [7:0]  r_op, r_second;
    logic [3:0]  r_cls;
    logic [15:0] r_operand, r_segment;
    logic        r_fault;

    logic [15:0] operand, segment;
    logic [7:0]  second;
    logic [3:0]  cls;

    assign o_pop = !i_empty && (!r_valid || !i_out_stall);

    always_comb begin
        operand = 16'h0000;
        segment = 16'h0000;
        if (!i_rec.fault) begin
            if (i_rec.form.has2) begin
                if (i_rec.form.len == 3'd3) begin
                    operand = {8'h00, i_rec.bytes[2]};
                end else if (i_rec.form.len >= 3'd4) begin
                    operand = {i_rec.bytes[3], i_rec.bytes[2]};
                end
            end else begin
                if (i_rec.form.len == 3'd2) begin
                    operand = {8'h00, i_rec.bytes[1]};
                end else if (i_rec.form.len >= 3'd3) begin
                    operand = {i_rec.bytes[2], i_rec.bytes[1]};
                end
            end
            if (i_rec.form.cls == FC_FAR) begin
                segment = {i_rec.bytes[4], i_rec.bytes[3]};
            end
        end
        second = (i_rec.form.has2 || i_rec.fault) ? i_rec.bytes[1] : 8'h00;
        cls    = i_rec.fault ? FC_NONE : i_rec.form.cls;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_start   <= i_rec.start;
            r_len     <= i_rec.form.len;
            r_op      <= i_rec.bytes[0];
            r_second  <= second;
            r_cls     <= cls;
            r_operand <= operand;
            r_segment <= segment;
            r_fault   <= i_rec.fault;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_start_offset  = r_start;
    assign o_instr_length  = r_len;
    assign o_opcode_byte   = r_op;
    assign o_second_byte   = r_second;
    assign o_form_class    = r_cls;
    assign o_operand_value = r_operand;
    assign o_segment_value = r_segment;
    assign o_fault         = r_fault;

endmodule

FILE: hw/rtl/x86_real_mode_instruction_decoder.sv
// A word enters the queue on its last code byte, then the output register on a pop.
// Throughput: one code byte per cycle; the front stalls only when the four-word
//   queue to the output stage is full.
// Reset: synchronous, active low; clears offsets, byte count, halt flag, queue
//   and output valid. After a fault word the decoder takes bytes and drops them.
module x86_real_mode_instruction_decoder #(
    parameter int OFFSET_BITS = x86rmd_pkg::OFFSET_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_code_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_start_offset,
    output logic [2:0]  o_instr_length,
    output logic [7:0]  o_opcode_byte,
    output logic [7:0]  o_second_byte,
    output logic [3:0]  o_form_class,
    output logic [15:0] o_operand_value,
    output logic [15:0] o_segment_value,
    output logic        o_fault
);
    import x86rmd_pkg::*;

    logic full, empty, push, pop, accept;
    t_rec front_rec, head_rec;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    x86rmd_front #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_code_byte (i_code_byte),
        .o_push      (push),
        .o_rec       (front_rec)
    );

    x86rmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_rec   (head_rec)
    );

    x86rmd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (empty),
        .i_rec           (head_rec),
        .o_pop           (pop),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_start_offset  (o_start_offset),
        .o_instr_length  (o_instr_length),
        .o_opcode_byte   (o_opcode_byte),
        .o_second_byte   (o_second_byte),
        .o_form_class    (o_form_class),
        .o_operand_value (o_operand_value),
        .o_segment_value (o_segment_value),
        .o_fault         (o_fault)
    );

endmodule

FILE: hw/rtl/x86rmd_checker.sv
module x86rmd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_start_offset,
    input logic [2:0]  o_instr_length,
    input logic [7:0]  o_opcode_byte,
    input logic [7:0]  o_second_byte,
    input logic [3:0]  o_form_class,
    input logic [15:0] o_operand_value,
    input logic [15:0] o_segment_value,
    input logic        o_fault
);
    import x86rmd_pkg::*;

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_stalled_word_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_start_offset) &&
        $stable(o_second_byte) && $stable(o_operand_value) && $stable(o_fault))
        else $error("stalled output word changed");

    a_fault_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_fault && !i_out_stall |=> !o_out_valid)
        else $error("word delivered after fault");

    a_fault_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_fault |-> o_instr_length == 3'd2 && o_form_class == FC_NONE &&
        o_operand_value == 16'h0000 && o_segment_value == 16'h0000)
        else $error("malformed fault word");

    a_far_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_fault && o_form_class == FC_FAR |-> o_instr_length == 3'd5 &&
        o_opcode_byte == OP_JMPF)
        else $error("far jump word has wrong length");

endmodule

bind x86_real_mode_instruction_decoder x86rmd_checker u_checker (.*);

FILE: tb/x86_real_mode_instruction_decoder_tb.sv
`timescale 1ns / 100ps

module x86_real_mode_instruction_decoder_tb;
    import x86rmd_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 24;

    localparam logic [7:0] OP_PUSH_ES     = 8'h06;
    localparam logic [7:0] OP_POP_ES      = 8'h07;
    localparam logic [7:0] OP_PUSH_DS     = 8'h1e;
    localparam logic [7:0] OP_POP_DS      = 8'h1f;
    localparam logic [7:0] OP_AND_AL_IB   = 8'h24;
    localparam logic [7:0] OP_XOR_EV_GV   = 8'h31;
    localparam logic [7:0] OP_CMP_AL_IB   = 8'h3c;
    localparam logic [7:0] OP_INC_AX      = 8'h40;
    localparam logic [7:0] OP_POPA        = 8'h61;
    localparam logic [7:0] OP_OPSIZE      = 8'h66;
    localparam logic [7:0] OP_JZ_SHORT    = 8'h74;
    localparam logic [7:0] OP_JG_SHORT    = 8'h7f;
    localparam logic [7:0] OP_GRP1_EB_IB  = 8'h80;
    localparam logic [7:0] OP_GRP1_EV_IB  = 8'h83;
    localparam logic [7:0] OP_TEST_EB_GB  = 8'h84;
    localparam logic [7:0] OP_MOV_EB_GB   = 8'h88;
    localparam logic [7:0] OP_MOV_EV_GV   = 8'h89;
    localparam logic [7:0] OP_MOV_GB_EB   = 8'h8a;
    localparam logic [7:0] OP_MOV_GV_EV   = 8'h8b;
    localparam logic [7:0] OP_MOV_EV_SREG = 8'h8c;
    localparam logic [7:0] OP_LEA         = 8'h8d;
    localparam logic [7:0] OP_MOV_SREG_EV = 8'h8e;
    localparam logic [7:0] OP_MOVSB       = 8'ha4;
    localparam logic [7:0] OP_STOSB       = 8'haa;
    localparam logic [7:0] OP_MOV_AL_IB   = 8'hb0;
    localparam logic [7:0] OP_MOV_BH_IB   = 8'hb7;
    localparam logic [7:0] OP_MOV_AX_IW   = 8'hb8;
    localparam logic [7:0] OP_MOV_DI_IW   = 8'hbf;
    localparam logic [7:0] OP_RET         = 8'hc3;
    localparam logic [7:0] OP_LES         = 8'hc4;
    localparam logic [7:0] OP_LDS         = 8'hc5;
    localparam logic [7:0] OP_JCXZ        = 8'he3;
    localparam logic [7:0] OP_IN_AL_IB    = 8'he4;
    localparam logic [7:0] OP_OUT_IB_AL   = 8'he6;
    localparam logic [7:0] OP_CALL_REL    = 8'he8;
    localparam logic [7:0] OP_JMP_REL     = 8'he9;
    localparam logic [7:0] OP_REP         = 8'hf3;
    localparam logic [7:0] OP_CLI         = 8'hfa;
    localparam logic [7:0] OP_STD         = 8'hfd;

    localparam logic [7:0] SUB_JZ_NEAR    = 8'h84;
    localparam logic [7:0] SUB_JNZ_NEAR   = 8'h85;

    localparam logic [1:0] MOD_MEM   = 2'b00;
    localparam logic [1:0] MOD_DISP8 = 2'b01;
    localparam logic [1:0] MOD_REG   = 2'b11;
    localparam logic [2:0] RM_BP     = 3'b110;
    localparam logic [2:0] REG_ADD   = 3'b000;
    localparam logic [2:0] SREG_CS   = 3'b001;
    localparam logic [2:0] SREG_DS   = 3'b011;

    typedef enum {BAD_FIRST, BAD_GRP1, BAD_TWO_BYTE, BAD_MODRM} t_fault_kind;

    typedef struct packed {
        logic [2:0] len;
        logic [3:0] cls;
        logic       has_modrm;
    } t_shape;

    typedef struct packed {
        logic [15:0] start;
        logic [2:0]  len;
        logic [7:0]  opcode;
        logic [7:0]  second;
        logic [3:0]  cls;
        logic [15:0] operand;
        logic [15:0] segment;
        logic        fault;
    } t_instr_word;

    typedef struct packed {
        logic [7:0] code;
        logic [4:0] gap;
    } t_code_word;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_code_byte = 8'h00;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [15:0] o_start_offset;
    logic [2:0]  o_instr_length;
    logic [7:0]  o_opcode_byte;
    logic [7:0]  o_second_byte;
    logic [3:0]  o_form_class;
    logic [15:0] o_operand_value;
    logic [15:0] o_segment_value;
    logic        o_fault;

    t_code_word  code_stream[$];
    t_instr_word expected_instrs[$];
    logic [7:0]  simple_ops[$];
    logic [7:0]  modrm_ops[$];

    logic [15:0] pc_offset    = '0;
    logic [15:0] instr_origin = '0;
    logic [7:0]  instr_bytes [NUM_BYTES];
    int          bytes_in     = 0;
    int          bytes_due    = 0;
    bit          stopped      = 1'b0;

    int unsigned tx_calm       = 0;
    int unsigned rx_calm       = 0;
    int unsigned idle_left     = 0;
    int unsigned stall_left    = 0;
    int unsigned quiet_cycles  = 0;
    int          queued_bytes  = 0;
    int          bytes_taken   = 0;
    int          bytes_dropped = 0;
    int          instrs_checked = 0;
    int          faults_seen   = 0;
    int          errors        = 0;

    x86_real_mode_instruction_decoder u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_code_byte     (i_code_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_start_offset  (o_start_offset),
        .o_instr_length  (o_instr_length),
        .o_opcode_byte   (o_opcode_byte),
        .o_second_byte   (o_second_byte),
        .o_form_class    (o_form_class),
        .o_operand_value (o_operand_value),
        .o_segment_value (o_segment_value),
        .o_fault         (o_fault)
    );

    function automatic t_shape classify(input logic [7:0] op, input logic [7:0] mrm);
        t_shape s;
        s.len       = 3'd0;
        s.cls       = FC_NONE;
        s.has_modrm = 1'b0;
        if (op inside {[OP_INC_AX:OP_POPA], OP_PUSH_ES, OP_POP_ES, OP_PUSH_DS, OP_POP_DS,
                       OP_OPSIZE, OP_MOVSB, OP_STOSB, OP_RET, OP_REP, [OP_CLI:OP_STD]}) begin
            s.len = 3'd1;
        end else if (op inside {[OP_JZ_SHORT:OP_JG_SHORT], [OP_MOV_AL_IB:OP_MOV_BH_IB],
                                OP_AND_AL_IB, OP_CMP_AL_IB, OP_JCXZ, OP_IN_AL_IB,
                                OP_OUT_IB_AL}) begin
            s.len = 3'd2;
            s.cls = FC_IMM8;
        end else if (op inside {[OP_MOV_AX_IW:OP_MOV_DI_IW]}) begin
            s.len = 3'd3;
            s.cls = FC_IMM16;
        end else if (op inside {OP_CALL_REL, OP_JMP_REL}) begin
            s.len = 3'd3;
            s.cls = FC_REL16;
        end else if (op == OP_JMPF) begin
            s.len = 3'd5;
            s.cls = FC_FAR;
        end else begin
            s.has_modrm = 1'b1;
            case (op)
                OP_TWO_BYTE: begin
                    if (mrm inside {SUB_JZ_NEAR, SUB_JNZ_NEAR}) begin
                        s.len = 3'd4;
                        s.cls = FC_REL16;
                    end
                end
                OP_XOR_EV_GV, OP_TEST_EB_GB: begin
                    if (mrm[7:6] == MOD_REG) begin
                        s.len = 3'd2;
                        s.cls = FC_REGREG;
                    end
                end
                OP_GRP1_EB_IB: begin
                    if (mrm[7:3] == {MOD_MEM, REG_ADD}) begin
                        s.len = 3'd3;
                        s.cls = FC_MRM_IMM;
                    end
                end
                OP_GRP1_EV_IB: begin
                    if (mrm[7:3] == {MOD_REG, REG_ADD}) begin
                        s.len = 3'd3;
                        s.cls = FC_MRM_IMM;
                    end
                end
                OP_MOV_EB_GB: begin
                    if (mrm[7:6] == MOD_DISP8) begin
                        s.len = 3'd3;
                        s.cls = FC_DISP8;
                    end else if (mrm[7:6] == MOD_REG) begin
                        s.len = 3'd2;
                        s.cls = FC_REGREG;
                    end
                end
                OP_MOV_EV_GV: begin
                    if (mrm[7:6] == MOD_DISP8 && mrm[2:0] == RM_BP) begin
                        s.len = 3'd3;
                        s.cls = FC_DISP8;
                    end else if (mrm[7:6] == MOD_REG) begin
                        s.len = 3'd2;
                        s.cls = FC_REGREG;
                    end
                end
                OP_MOV_GB_EB: begin
                    if (mrm[7:6] == MOD_MEM && mrm[2:0] == RM_BP) begin
                        s.len = 3'd4;
                        s.cls = FC_DISP16;
                    end else if (mrm[7:6] == MOD_MEM) begin
                        s.len = 3'd2;
                        s.cls = FC_MEM;
                    end else if (mrm[7:6] == MOD_DISP8 && mrm[2:0] == RM_BP) begin
                        s.len = 3'd3;
                        s.cls = FC_DISP8;
                    end
                end
                OP_MOV_GV_EV, OP_LEA: begin
                    if (mrm[7:6] == MOD_DISP8 && mrm[2:0] == RM_BP) begin
                        s.len = 3'd3;
                        s.cls = FC_DISP8;
                    end
                end
                OP_MOV_EV_SREG: begin
                    if (mrm[7:3] == {MOD_REG, SREG_CS}) begin
                        s.len = 3'd2;
                        s.cls = FC_REGREG;
                    end
                end
                OP_MOV_SREG_EV: begin
                    if (mrm == {MOD_DISP8, SREG_DS, RM_BP}) begin
                        s.len = 3'd3;
                        s.cls = FC_DISP8;
                    end
                end
                OP_LES, OP_LDS: begin
                    if (mrm[7:6] == MOD_DISP8) begin
                        s.len = 3'd3;
                        s.cls = FC_DISP8;
                    end
                end
                default: begin
                end
            endcase
        end
        return s;
    endfunction

    function automatic void post_decode(input t_shape s, input logic flt);
        t_instr_word w;
        int          p;
        p       = s.has_modrm ? 2 : 1;
        w       = '0;
        w.start = instr_origin;
        w.opcode = instr_bytes[0];
        w.fault = flt;
        if (flt) begin
            w.len    = 3'd2;
            w.second = instr_bytes[1];
        end else begin
            w.len = s.len;
            w.cls = s.cls;
            if (s.has_modrm) begin
                w.second = instr_bytes[1];
            end
            if (s.len == p + 1) begin
                w.operand = {8'h00, instr_bytes[p]};
            end else if (s.len >= p + 2) begin
                w.operand = {instr_bytes[p + 1], instr_bytes[p]};
            end
            if (s.cls == FC_FAR) begin
                w.segment = {instr_bytes[4], instr_bytes[3]};
            end
        end
        expected_instrs.push_back(w);
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        t_shape s;
        if (stopped) begin
            bytes_dropped++;
            return;
        end
        if (bytes_in == 0) begin
            instr_origin = pc_offset;
        end
        if (bytes_in < NUM_BYTES) begin
            instr_bytes[bytes_in] = b;
        end
        bytes_in++;
        pc_offset++;
        if (bytes_in == 1) begin
            s = classify(instr_bytes[0], 8'h00);
            if (s.len == 3'd1) begin
                post_decode(s, 1'b0);
                bytes_in  = 0;
                bytes_due = 0;
            end else begin
                bytes_due = 2;
            end
            return;
        end
        if (bytes_in == 2) begin
            s = classify(instr_bytes[0], instr_bytes[1]);
            if (s.len == 3'd0) begin
                post_decode(s, 1'b1);
                stopped   = 1'b1;
                bytes_in  = 0;
                bytes_due = 0;
                return;
            end
            bytes_due = s.len;
        end
        if (bytes_in >= bytes_due || bytes_in >= NUM_BYTES) begin
            s = classify(instr_bytes[0], instr_bytes[1]);
            post_decode(s, 1'b0);
            bytes_in  = 0;
            bytes_due = 0;
        end
    endfunction

    function automatic int unsigned draw_wait(inout int unsigned calm);
        if (calm != 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(16, 64);
            return 0;
        end
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic logic [7:0] pick_modrm(input logic [7:0] op);
        logic [7:0] r;
        r = 8'($urandom);
        case (op)
            OP_TWO_BYTE:                 return r[0] ? SUB_JZ_NEAR : SUB_JNZ_NEAR;
            OP_XOR_EV_GV, OP_TEST_EB_GB: return {MOD_REG, r[5:0]};
            OP_GRP1_EB_IB:               return {MOD_MEM, REG_ADD, r[2:0]};
            OP_GRP1_EV_IB:               return {MOD_REG, REG_ADD, r[2:0]};
            OP_MOV_EB_GB:                return {r[7] ? MOD_DISP8 : MOD_REG, r[5:0]};
            OP_MOV_EV_GV: begin
                return r[7] ? {MOD_DISP8, r[5:3], RM_BP} : {MOD_REG, r[5:0]};
            end
            OP_MOV_GB_EB: begin
                case (r[7:6])
                    2'b00:   return {MOD_MEM, r[5:3], RM_BP};
                    2'b01:   return {MOD_DISP8, r[5:3], RM_BP};
                    default: return {MOD_MEM, r[5:0]};
                endcase
            end
            OP_MOV_GV_EV, OP_LEA:        return {MOD_DISP8, r[5:3], RM_BP};
            OP_MOV_EV_SREG:              return {MOD_REG, SREG_CS, r[2:0]};
            OP_MOV_SREG_EV:              return {MOD_DISP8, SREG_DS, RM_BP};
            OP_LES, OP_LDS:              return {MOD_DISP8, r[5:0]};
            default:                     return r;
        endcase
    endfunction

    task automatic queue_byte(input logic [7:0] b, input bit rushed);
        t_code_word cw;
        cw.code = b;
        cw.gap  = rushed ? 5'd0 : 5'(draw_wait(tx_calm));
        code_stream.push_back(cw);
        queued_bytes++;
    endtask

    task automatic queue_random_instr(input bit rushed);
        logic [7:0] op;
        logic [7:0] mrm;
        t_shape     s;
        int         tail;
        if ($urandom_range(0, 1) == 0) begin
            op = simple_ops[$urandom_range(0, simple_ops.size() - 1)];
        end else begin
            op = modrm_ops[$urandom_range(0, modrm_ops.size() - 1)];
        end
        mrm  = pick_modrm(op);
        s    = classify(op, mrm);
        tail = int'(s.len) - (s.has_modrm ? 2 : 1);
        queue_byte(op, rushed);
        if (s.has_modrm) begin
            queue_byte(mrm, rushed);
        end
        repeat (tail) queue_byte(8'($urandom), rushed);
    endtask

    // end the stream with one unsupported instruction, then bytes the halted decoder drops
    task automatic queue_fault();
        t_fault_kind kind;
        logic [7:0]  op;
        logic [7:0]  nxt;
        t_shape      s;
        kind = t_fault_kind'($urandom_range(0, 3));
        case (kind)
            BAD_FIRST: begin
                do begin
                    case ($urandom_range(0, 2))
                        0:       op = 8'h00;
                        1:       op = 8'hff;
                        default: op = 8'($urandom);
                    endcase
                    s = classify(op, pick_modrm(op));
                end while (s.len != 3'd0);
            end
            BAD_GRP1:     op = OP_GRP1_EB_IB;
            BAD_TWO_BYTE: op = OP_TWO_BYTE;
            default:      op = modrm_ops[$urandom_range(0, modrm_ops.size() - 1)];
        endcase
        do begin
            nxt = 8'($urandom);
            s   = classify(op, nxt);
        end while (s.len != 3'd0);
        queue_byte(op, 1'b0);
        queue_byte(nxt, 1'b0);
        repeat (12) queue_byte(8'($urandom), 1'b0);
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            errors++;
            $error("%s: expected %h, got %h", name, want, got);
        end
    endfunction

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin : driver
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            idle_left  <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                decode_byte(i_code_byte);
                bytes_taken++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (idle_left != 0) begin
                    idle_left  <= idle_left - 1;
                    i_in_valid <= 1'b0;
                end else if (code_stream.size() != 0) begin
                    i_in_valid  <= 1'b1;
                    i_code_byte <= code_stream[0].code;
                    idle_left   <= 32'(code_stream[0].gap);
                    void'(code_stream.pop_front());
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_instr_word want;
        int unsigned w;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else begin
            w = stall_left;
            if (o_out_valid && !i_out_stall) begin
                if (expected_instrs.size() == 0) begin
                    errors++;
                    $error("decoded word at offset %h with nothing expected", o_start_offset);
                end else begin
                    want = expected_instrs.pop_front();
                    check_field("start_offset", want.start, o_start_offset);
                    check_field("instr_length", 16'(want.len), 16'(o_instr_length));
                    check_field("opcode_byte", 16'(want.opcode), 16'(o_opcode_byte));
                    check_field("second_byte", 16'(want.second), 16'(o_second_byte));
                    check_field("form_class", 16'(want.cls), 16'(o_form_class));
                    check_field("operand_value", want.operand, o_operand_value);
                    check_field("segment_value", want.segment, o_segment_value);
                    check_field("fault", 16'(want.fault), 16'(o_fault));
                    if (want.fault) begin
                        faults_seen++;
                    end
                    instrs_checked++;
                end
                w = draw_wait(rx_calm);
            end
            if (w != 0) begin
                i_out_stall <= 1'b1;
                stall_left  <= w - 1;
            end else begin
                i_out_stall <= 1'b0;
                stall_left  <= 0;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** x86_real_mode_instruction_decoder: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [7:0] opening[$];
        t_shape     s;
        for (int v = 0; v < 256; v++) begin
            s = classify(8'(v), pick_modrm(8'(v)));
            if (s.len != 3'd0) begin
                if (s.has_modrm) begin
                    modrm_ops.push_back(8'(v));
                end else begin
                    simple_ops.push_back(8'(v));
                end
            end
        end

        opening = '{OP_INC_AX, OP_POPA,
                    OP_MOV_AL_IB, 8'hff,
                    OP_MOV_AX_IW, 8'h00, 8'hff,
                    OP_XOR_EV_GV, 8'hc0,
                    OP_MOV_EB_GB, 8'h40, 8'h80,
                    OP_MOV_GB_EB, 8'h06, 8'h34, 8'h12,
                    OP_MOV_GB_EB, 8'h00,
                    OP_GRP1_EB_IB, 8'h06, 8'hff,
                    OP_TWO_BYTE, SUB_JZ_NEAR, 8'hfe, 8'hff,
                    OP_JMPF, 8'h01, 8'h02, 8'h03, 8'h04};
        foreach (opening[i]) queue_byte(opening[i], 1'b0);

        while (queued_bytes < 500) queue_random_instr(1'b0);
        // burst with no input gaps
        while (queued_bytes < 700) queue_random_instr(1'b1);
        while (queued_bytes < 1080) queue_random_instr(1'b0);
        queue_fault();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
        end while (code_stream.size() != 0 || i_in_valid || expected_instrs.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d decoded words from %0d code bytes, %0d dropped after %0d fault(s)",
                 instrs_checked, bytes_taken, bytes_dropped, faults_seen);
        $display("random gaps, output stalls and a gapless burst; %0d mismatches", errors);
        if (errors == 0) begin
            $display("** x86_real_mode_instruction_decoder: PASSED **");
        end else begin
            $display("** x86_real_mode_instruction_decoder: FAILED **");
        end
        $finish;
    end

endmodule

FILE: x86_real_mode_instruction_decoder.f
hw/rtl/x86rmd_pkg.sv
hw/rtl/x86rmd_front.sv
hw/rtl/x86rmd_queue.sv
hw/rtl/x86rmd_back.sv
hw/rtl/x86_real_mode_instruction_decoder.sv
hw/rtl/x86rmd_checker.sv
tb/x86_real_mode_instruction_decoder_tb.sv
